// ----- src/mpeg_audio_frame_sync_macros.svh -----
// Assertion macros shared by the MPEG audio frame sync RTL.
`ifndef MPEG_AUDIO_FRAME_SYNC_MACROS_SVH
`define MPEG_AUDIO_FRAME_SYNC_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define MAFS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition that implies another one at the same edge.
`define MAFS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that implies another one at the next edge.
`define MAFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/mafs_pkg.sv -----
// Constants, types and header lookup tables for the MPEG audio frame sync.
`timescale 1ns / 1ps
`default_nettype none

package mafs_pkg;

    localparam int OFFSET_BITS = 32;
    typedef logic [OFFSET_BITS-1:0] pos_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_MATCH_ENABLE = 2'd0;
    localparam logic [1:0] REG_REFERENCE    = 2'd1;
    localparam logic [1:0] REG_MASK         = 2'd2;

    // Quotient bits of the frame length division.
    localparam int DIV_STEPS = 12;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Bitrate in kbit/s divided by 8, by [MPEG-2 or 2.5][3 - layer][index].
    localparam logic [5:0] RATE_TAB [2][4][16] = '{
        '{ '{6'd0, 6'd4, 6'd8, 6'd12, 6'd16, 6'd20, 6'd24, 6'd28,
             6'd32, 6'd36, 6'd40, 6'd44, 6'd48, 6'd52, 6'd56, 6'd0},
           '{6'd0, 6'd4, 6'd6, 6'd7, 6'd8, 6'd10, 6'd12, 6'd14,
             6'd16, 6'd20, 6'd24, 6'd28, 6'd32, 6'd40, 6'd48, 6'd0},
           '{6'd0, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd10, 6'd12,
             6'd14, 6'd16, 6'd20, 6'd24, 6'd28, 6'd32, 6'd40, 6'd0},
           '{16{6'd0}} },
        '{ '{6'd0, 6'd4, 6'd6, 6'd7, 6'd8, 6'd10, 6'd12, 6'd14,
             6'd16, 6'd18, 6'd20, 6'd22, 6'd24, 6'd28, 6'd32, 6'd0},
           '{6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7,
             6'd8, 6'd10, 6'd12, 6'd14, 6'd16, 6'd18, 6'd20, 6'd0},
           '{6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7,
             6'd8, 6'd10, 6'd12, 6'd14, 6'd16, 6'd18, 6'd20, 6'd0},
           '{16{6'd0}} }
    };

    // Sample rate in Hz by [3 - version][index].
    localparam logic [15:0] SRATE_TAB [4][4] = '{
        '{16'd44100, 16'd48000, 16'd32000, 16'd0},
        '{16'd22050, 16'd24000, 16'd16000, 16'd0},
        '{16'd0,     16'd0,     16'd0,     16'd0},
        '{16'd11025, 16'd12000, 16'd8000,  16'd0}
    };

    // Samples per frame divided by 8, by [MPEG-2 or 2.5][3 - layer].
    localparam logic [7:0] SAMP_TAB [2][4] = '{
        '{8'd48, 8'd144, 8'd144, 8'd0},
        '{8'd48, 8'd144, 8'd72,  8'd0}
    };

    function automatic logic header_valid(input logic [31:0] w);
        logic sync_ok;
        sync_ok = (w[31:21] == 11'h7ff);
        return sync_ok && (w[20:19] != 2'd1) && (w[18:17] != 2'd0)
            && (w[15:12] != 4'd0) && (w[15:12] != 4'd15) && (w[11:10] != 2'd3);
    endfunction

endpackage

`default_nettype wire

// ----- src/mpeg_audio_frame_sync.sv -----
// Top level of the MPEG audio frame header sync: byte window, header check and length unit.
`timescale 1ns / 1ps
`default_nettype none
`include "mpeg_audio_frame_sync_macros.svh"

// Scans a byte stream for MPEG audio frame headers and reports each one with
// its offset, bitrate, sample rate, samples per frame and frame length.
// A byte that does not complete a header is taken straight into the window. A byte that
// does is accepted, then the product of samples and bitrate is formed and scaled,
// a restoring divider yields the twelve quotient bits at one per cycle, and
// the result is handed to the output register; s_tready is low meanwhile.
// The last step waits, with s_tready still low, while the output register
// holds a report that has not been taken yet.
// The output register lets the next byte transfer while a report waits.
// Registers 0, 1 and 2 are match_enable, reference_header and compare_mask.
module mpeg_audio_frame_sync (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // data_byte
    input  wire logic          s_tuser,   // new_buffer
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // header_offset[31:0], header_word[63:32], bitrate_kbps[72:64],
    // sample_rate_hz[88:73], frame_samples[99:89], frame_length[111:100]
    output logic [111:0]       m_tdata,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [31:0]   cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_SCALE = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;

    logic        match_en_reg;
    logic [31:0] ref_reg;
    logic [31:0] mask_reg;

    logic [23:0]        window_reg, window_next;
    logic [1:0]         fill_reg, fill_next;
    mafs_pkg::pos_t     pos_reg, pos_next;

    // Working registers of the header in progress.
    logic [31:0] offset_reg, offset_next;
    logic [31:0] word_reg, word_next;
    logic [5:0]  rate_reg, rate_next;
    logic [15:0] hz_reg, hz_next;
    logic [7:0]  s8_reg, s8_next;
    logic        pad_reg, pad_next;
    logic        layer1_reg, layer1_next;
    logic [13:0] prod_reg, prod_next;
    logic [15:0] rem_reg, rem_next;
    logic [11:0] nlow_reg, nlow_next;
    logic [11:0] quot_reg, quot_next;
    logic [mafs_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic         out_valid_reg, out_valid_next;
    logic [111:0] out_data_reg, out_data_next;

    logic           accept;
    logic [23:0]    eff_window;
    logic [1:0]     eff_fill;
    mafs_pkg::pos_t eff_pos;
    logic [31:0]    cand;
    logic           hit;
    logic           vi;
    logic [1:0]     li;
    logic [25:0]    num;
    logic [16:0]    trial;
    logic           trial_ge;
    logic [11:0]    length;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        eff_window = s_tuser ? 24'd0 : window_reg;
        eff_fill   = s_tuser ? 2'd0 : fill_reg;
        eff_pos    = s_tuser ? '0 : pos_reg;
        cand       = {eff_window, s_tdata};
        hit = (eff_fill == 2'd3) && mafs_pkg::header_valid(cand)
            && (!match_en_reg || (((cand ^ ref_reg) & mask_reg) == 32'd0));
        vi  = (cand[20:19] != 2'd3);
        li  = 2'd3 - cand[18:17];
        num = 26'(32'(prod_reg) * 32'd8000);
        trial    = {rem_reg, nlow_reg[11]};
        trial_ge = (trial >= {1'b0, hz_reg});
        length   = quot_reg + (layer1_reg ? {9'd0, pad_reg, 2'd0} : {11'd0, pad_reg});
    end

    always_comb
    begin
        state_next     = state_reg;
        window_next    = window_reg;
        fill_next      = fill_reg;
        pos_next       = pos_reg;
        offset_next    = offset_reg;
        word_next      = word_reg;
        rate_next      = rate_reg;
        hz_next        = hz_reg;
        s8_next        = s8_reg;
        pad_next       = pad_reg;
        layer1_next    = layer1_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        nlow_next      = nlow_reg;
        quot_next      = quot_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    window_next = {eff_window[15:0], s_tdata};
                    fill_next   = (eff_fill == 2'd3) ? 2'd3 : eff_fill + 2'd1;
                    pos_next    = eff_pos + mafs_pkg::pos_t'(1);
                    if (hit)
                    begin
                        offset_next = 32'(mafs_pkg::pos_t'(eff_pos - mafs_pkg::pos_t'(3)));
                        word_next   = cand;
                        rate_next   = mafs_pkg::RATE_TAB[vi][li][cand[15:12]];
                        hz_next     = mafs_pkg::SRATE_TAB[2'd3 - cand[20:19]][cand[11:10]];
                        s8_next     = mafs_pkg::SAMP_TAB[vi][li];
                        pad_next    = cand[9];
                        layer1_next = (li == 2'd0);
                        state_next  = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = 14'(16'(s8_reg) * 16'(rate_reg));
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                // The quotient stays below 4096, so the upper bits are below the divisor.
                rem_next   = {2'd0, num[25:12]};
                nlow_next  = num[11:0];
                quot_next  = 12'd0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next  = trial_ge ? 16'(trial - {1'b0, hz_reg}) : trial[15:0];
                nlow_next = {nlow_reg[10:0], 1'b0};
                quot_next = {quot_reg[10:0], trial_ge};
                cnt_next  = cnt_reg + mafs_pkg::DIV_CNT_W'(1);
                if (cnt_reg == mafs_pkg::DIV_CNT_W'(mafs_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {length, {s8_reg, 3'd0}, hz_reg,
                                      {rate_reg, 3'd0}, word_reg, offset_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            match_en_reg  <= 1'b0;
            ref_reg       <= 32'd0;
            mask_reg      <= 32'd0;
            window_reg    <= 24'd0;
            fill_reg      <= 2'd0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mafs_pkg::REG_MATCH_ENABLE: match_en_reg <= cfg_data[0];
                    mafs_pkg::REG_REFERENCE:    ref_reg      <= cfg_data;
                    mafs_pkg::REG_MASK:         mask_reg     <= cfg_data;
                    default:                    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        offset_reg   <= offset_next;
        word_reg     <= word_next;
        rate_reg     <= rate_next;
        hz_reg       <= hz_next;
        s8_reg       <= s8_next;
        pad_reg      <= pad_next;
        layer1_reg   <= layer1_next;
        prod_reg     <= prod_next;
        rem_reg      <= rem_next;
        nlow_reg     <= nlow_next;
        quot_reg     <= quot_next;
        out_data_reg <= out_data_next;
    end

    `MAFS_ASSERT_SAME(a_div_count, state_reg == ST_DIV, cnt_reg < mafs_pkg::DIV_CNT_W'(mafs_pkg::DIV_STEPS), "divider step count overran")
    `MAFS_ASSERT_SAME(a_div_rem, state_reg == ST_DIV, rem_reg < hz_reg, "partial remainder not below the sample rate")
    `MAFS_ASSERT_NEXT(a_hit_starts, accept && hit, state_reg == ST_MUL && !s_tready, "header hit did not start the length unit")

endmodule

`default_nettype wire
